FILE: design/eic_pkg.sv
// ----------------------------------------------------------------------------
// eic_pkg
// Shared types and constants of the elementary interval cover block.
// ----------------------------------------------------------------------------
package eic_pkg;

    // Width of the border fields on the result ports.
    localparam int OUT_BORDER_WIDTH = 32;

    // Width of the membership mask on the result ports.
    localparam int MASK_WIDTH = 16;

    // States of the back-end sequencer.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_INS_HIGH,
        BK_EMIT
    } t_back_state;

endpackage

FILE: design/elementary_interval_cover.sv
// ----------------------------------------------------------------------------
// elementary_interval_cover
// Splits a set of intervals into elementary segments with membership masks.
// ----------------------------------------------------------------------------
// Input channel: an item (interval_low, interval_high, last_interval) is
// taken when push is high and full is low. Up to MAX_INTERVALS intervals of
// a set are kept; further ones are dropped, though a dropped item with the
// last flag still closes the set.
// Result channel: while empty is low the oldest segment is on the o_ ports;
// pop takes it. A set of N kept intervals gives 2N-1 segments, the final
// one flagged by o_last_segment. Equal neighbouring borders give a segment
// with zero borders and mask.
// Operation: the back end inserts the two borders of each kept interval
// into a sorted register row, the low one in BK_IDLE and the high one in
// BK_INS_HIGH, then emits the segments one by one in BK_EMIT, holding
// while the result queue is full. A two-entry queue lets the front keep
// accepting while the back end works, until it fills.
// Reset clears all control state; no clearing pass is needed. When the
// receiver stalls, the result queue fills, the back end holds, and full
// rises once the input queue is full too.
// ----------------------------------------------------------------------------
module elementary_interval_cover #(
    parameter int MAX_INTERVALS = 16,
    parameter int BORDER_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_interval_low,
    input  logic [31:0] i_interval_high,
    input  logic        i_last_interval,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_segment_low,
    output logic [31:0] o_segment_high,
    output logic [15:0] o_member_mask,
    output logic        o_last_segment
);

    localparam int QW = 2 * BORDER_WIDTH + 2;
    localparam int RW = 2 * eic_pkg::OUT_BORDER_WIDTH + eic_pkg::MASK_WIDTH + 1;

    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    logic [QW-1:0] q_rdata;
    logic          res_push;
    logic [RW-1:0] res_wdata;
    logic          res_full;
    logic [RW-1:0] res_rdata;

    // Front end: accept and classify.
    eic_front #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .BORDER_WIDTH (BORDER_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_low   (i_interval_low),
        .i_high  (i_interval_high),
        .i_last  (i_last_interval),
        .o_full  (full),
        .i_q_full(q_full),
        .o_q_push(q_push),
        .o_q_data(q_wdata)
    );

    // Queue between front and back end.
    eic_fifo #(
        .WIDTH(QW)
    ) u_item_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_wdata),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_data (q_rdata)
    );

    // Back end: sort and emit.
    eic_back #(
        .MAX_INTERVALS(MAX_INTERVALS),
        .BORDER_WIDTH (BORDER_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_res_full(res_full),
        .o_res_push(res_push),
        .o_res_data(res_wdata)
    );

    // Result queue in front of the output ports.
    eic_fifo #(
        .WIDTH(RW)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_wdata),
        .o_full (res_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (res_rdata)
    );

    assign o_segment_low  = res_rdata[RW-1:RW-32];
    assign o_segment_high = res_rdata[RW-33:RW-64];
    assign o_member_mask  = res_rdata[16:1];
    assign o_last_segment = res_rdata[0];

endmodule

FILE: design/eic_fifo.sv
// ----------------------------------------------------------------------------
// eic_fifo
// Two-entry first-in first-out queue for a packed payload.
// ----------------------------------------------------------------------------
module eic_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             do_push;
    logic             do_pop;

    // Handshake qualification.
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: design/eic_front.sv
// ----------------------------------------------------------------------------
// eic_front
// Accepts intervals, masks their borders and drops those beyond capacity.
// ----------------------------------------------------------------------------
module eic_front #(
    parameter int MAX_INTERVALS = 16,
    parameter int BORDER_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [31:0]               i_low,
    input  logic [31:0]               i_high,
    input  logic                      i_last,
    output logic                      o_full,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output logic [2*BORDER_WIDTH+1:0] o_q_data
);

    localparam int CW = $clog2(MAX_INTERVALS + 1);

    logic [CW-1:0] r_count;
    logic          accept;
    logic          keep;

    // An item is kept while the set has room; a dropped item still passes
    // on when it closes the set.
    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign keep     = (r_count < CW'(MAX_INTERVALS));
    assign o_q_push = accept && (keep || i_last);
    assign o_q_data = {BORDER_WIDTH'(i_low), BORDER_WIDTH'(i_high), i_last, keep};

    // Interval count of the set being loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_count <= '0;
            end else if (keep) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

endmodule

FILE: design/eic_back.sv
// ----------------------------------------------------------------------------
// eic_back
// Stores intervals, insertion-sorts their borders into a register row and
// emits one segment per neighbouring border pair.
// ----------------------------------------------------------------------------
module eic_back #(
    parameter int MAX_INTERVALS = 16,
    parameter int BORDER_WIDTH  = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  logic [2*BORDER_WIDTH+1:0] i_q_data,
    output logic                      o_q_pop,
    input  logic                      i_res_full,
    output logic                      o_res_push,
    output logic [2*eic_pkg::OUT_BORDER_WIDTH+eic_pkg::MASK_WIDTH:0] o_res_data
);

    localparam int NB     = 2 * MAX_INTERVALS;
    localparam int CW     = $clog2(MAX_INTERVALS + 1);
    localparam int LW     = $clog2(NB + 1);
    localparam int MASK_N = (MAX_INTERVALS < eic_pkg::MASK_WIDTH) ?
                            MAX_INTERVALS : eic_pkg::MASK_WIDTH;

    eic_pkg::t_back_state r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [LW-1:0]           r_len, n_len;
    logic [BORDER_WIDTH-1:0] r_lows  [MAX_INTERVALS];
    logic [BORDER_WIDTH-1:0] n_lows  [MAX_INTERVALS];
    logic [BORDER_WIDTH-1:0] r_highs [MAX_INTERVALS];
    logic [BORDER_WIDTH-1:0] n_highs [MAX_INTERVALS];
    logic [BORDER_WIDTH-1:0] r_row   [NB];
    logic [BORDER_WIDTH-1:0] n_row   [NB];
    logic [BORDER_WIDTH-1:0] ins_row [NB];
    logic [BORDER_WIDTH-1:0] r_high_hold, n_high_hold;
    logic                    r_last_hold, n_last_hold;

    logic [BORDER_WIDTH-1:0] q_low;
    logic [BORDER_WIDTH-1:0] q_high;
    logic                    q_last;
    logic                    q_keep;
    logic [BORDER_WIDTH-1:0] ins_val;
    logic [NB-1:0]           gt;
    logic [NB-1:0]           occ;

    logic [eic_pkg::MASK_WIDTH-1:0]       seg_mask;
    logic [63:0]                          seg_lo_ext;
    logic [63:0]                          seg_hi_ext;
    logic [eic_pkg::OUT_BORDER_WIDTH-1:0] seg_lo;
    logic [eic_pkg::OUT_BORDER_WIDTH-1:0] seg_hi;
    logic                                 seg_same;

    // Unpack the queued item.
    assign q_low  = i_q_data[2*BORDER_WIDTH+1:BORDER_WIDTH+2];
    assign q_high = i_q_data[BORDER_WIDTH+1:2];
    assign q_last = i_q_data[1];
    assign q_keep = i_q_data[0];

    // Insertion network: every slot decides from its own and its lower
    // neighbour's comparison whether it keeps, shifts up or takes the value.
    assign ins_val = (r_state == eic_pkg::BK_IDLE) ? q_low : r_high_hold;
    always_comb begin
        for (int j = 0; j < NB; j++) begin
            occ[j] = (LW'(j) < r_len);
            gt[j]  = (r_row[j] > ins_val);
        end
        for (int j = 0; j < NB; j++) begin
            if (occ[j] && !gt[j]) begin
                ins_row[j] = r_row[j];
            end else if (j > 0 && occ[(j > 0) ? j - 1 : 0] && gt[(j > 0) ? j - 1 : 0]) begin
                ins_row[j] = r_row[(j > 0) ? j - 1 : 0];
            end else begin
                ins_row[j] = ins_val;
            end
        end
    end

    // Segment at the head of the row and its enclosure mask.
    assign seg_same   = (r_row[0] == r_row[1]);
    assign seg_lo_ext = 64'(r_row[0]);
    assign seg_hi_ext = 64'(r_row[1]);
    assign seg_lo     = seg_same ? '0 : seg_lo_ext[eic_pkg::OUT_BORDER_WIDTH-1:0];
    assign seg_hi     = seg_same ? '0 : seg_hi_ext[eic_pkg::OUT_BORDER_WIDTH-1:0];
    always_comb begin
        seg_mask = '0;
        for (int k = 0; k < MASK_N; k++) begin
            seg_mask[k] = !seg_same && (CW'(k) < r_cnt) &&
                          (r_lows[k] <= r_row[0]) && (r_highs[k] >= r_row[1]);
        end
    end
    assign o_res_data = {seg_lo, seg_hi, seg_mask, (r_len == LW'(2))};

    // Sequencer: load two borders per kept item, then emit the run.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_row       = r_row;
        n_lows      = r_lows;
        n_highs     = r_highs;
        n_high_hold = r_high_hold;
        n_last_hold = r_last_hold;
        o_q_pop     = 1'b0;
        o_res_push  = 1'b0;
        unique case (r_state)
            eic_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop     = 1'b1;
                    n_high_hold = q_high;
                    n_last_hold = q_last;
                    if (q_keep) begin
                        n_row = ins_row;
                        n_len = r_len + LW'(1);
                        for (int k = 0; k < MAX_INTERVALS; k++) begin
                            if (CW'(k) == r_cnt) begin
                                n_lows[k]  = q_low;
                                n_highs[k] = q_high;
                            end
                        end
                        n_cnt   = r_cnt + CW'(1);
                        n_state = eic_pkg::BK_INS_HIGH;
                    end else begin
                        n_state = eic_pkg::BK_EMIT;
                    end
                end
            end
            eic_pkg::BK_INS_HIGH: begin
                n_row   = ins_row;
                n_len   = r_len + LW'(1);
                n_state = r_last_hold ? eic_pkg::BK_EMIT : eic_pkg::BK_IDLE;
            end
            eic_pkg::BK_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    for (int j = 0; j < NB - 1; j++) begin
                        n_row[j] = r_row[j + 1];
                    end
                    n_len = r_len - LW'(1);
                    if (r_len == LW'(2)) begin
                        n_cnt   = '0;
                        n_len   = '0;
                        n_state = eic_pkg::BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = eic_pkg::BK_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= eic_pkg::BK_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_lows      <= n_lows;
        r_highs     <= n_highs;
        r_row       <= n_row;
        r_high_hold <= n_high_hold;
        r_last_hold <= n_last_hold;
    end

    // The row never holds more than two borders per interval.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(NB))
        else $error("border row overflow");

    // A run always has at least one segment to give.
    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eic_pkg::BK_EMIT) |-> (r_len >= LW'(2)))
        else $error("emission started with fewer than two borders");

    // The head of the row is sorted while segments are emitted.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eic_pkg::BK_EMIT) |-> (r_row[0] <= r_row[1]))
        else $error("border row out of order");

    // Each stored interval adds exactly two borders.
    a_len_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == eic_pkg::BK_IDLE) |-> (32'(r_len) == 32'(r_cnt) * 2))
        else $error("border count does not match interval count");

endmodule
